### hw/rtl/ctkd_pkg.sv
package ctkd_pkg;

	localparam int FIELD_W = 16;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int LOCKOUT_SCANS_DEF = 3;

	localparam int CAL_DEPTH = 10;
	localparam int CAL_KEEP = 6;
	localparam int CAL_SKIP = 2;
	localparam int GROUP_NORMAL = 3;
	localparam int GROUP_CONT = 6;
	localparam int NEED_NORMAL = GROUP_NORMAL * 2 / 3;
	localparam int NEED_CONT = GROUP_CONT * 2 / 3;

	localparam int CNT_W = $clog2(CAL_DEPTH);
	localparam int GRP_W = 3;

	localparam logic OP_CAL = 1'b0;
	localparam logic OP_MEAS = 1'b1;

	localparam logic KIND_CAL = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	typedef struct packed {
		logic             cal_wr;
		logic             scan_wr;
		logic             sum_clear;
		logic             sum_add;
		logic [CNT_W-1:0] sum_idx;
		logic             mul_load;
		logic             base_load;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic cal_last;
		logic grp_last;
	} sts_t;

endpackage

### hw/rtl/ctkd_ctrl.sv
module ctkd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	output logic                out_valid,
	input  logic                out_ready,
	input  ctkd_pkg::sts_t      sts,
	output ctkd_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SUM  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_BASE = 3'd3;
	localparam logic [2:0] S_PUSH = 3'd4;

	localparam logic [ctkd_pkg::CNT_W-1:0] IDX_FIRST = ctkd_pkg::CNT_W'(ctkd_pkg::CAL_SKIP);
	localparam logic [ctkd_pkg::CNT_W-1:0] IDX_LAST =
		ctkd_pkg::CNT_W'(ctkd_pkg::CAL_SKIP + ctkd_pkg::CAL_KEEP - 1);

	logic [2:0]                    state_q;
	logic [2:0]                    state_nx;
	logic [ctkd_pkg::CNT_W-1:0]    idx_q;
	logic                          out_valid_q;
	logic                          accept;
	logic                          out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.cal_wr = accept && (operation == ctkd_pkg::OP_CAL);
		cmd.scan_wr = accept && (operation == ctkd_pkg::OP_MEAS);
		cmd.sum_idx = idx_q;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.cal_wr && sts.cal_last) begin
					cmd.sum_clear = 1'b1;
					state_nx = S_SUM;
				end else if (cmd.scan_wr && sts.grp_last) begin
					state_nx = S_PUSH;
				end
			end
			S_SUM: begin
				cmd.sum_add = 1'b1;
				if (idx_q == IDX_LAST) begin
					state_nx = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				state_nx = S_BASE;
			end
			S_BASE: begin
				cmd.base_load = 1'b1;
				state_nx = S_PUSH;
			end
			S_PUSH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= IDX_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.sum_clear) begin
				idx_q <= IDX_FIRST;
			end else if (cmd.sum_add) begin
				idx_q <= idx_q + 1'b1;
			end
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !cmd.out_load)
		else $error("result register overwritten while held");

	a_sum_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUM && idx_q != IDX_LAST |=> state_q == S_SUM)
		else $error("summation left before last middle entry");

	a_cal_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cal_wr && sts.cal_last |-> ##7 state_q == S_MUL)
		else $error("baseline division not reached on time");

	a_scan_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_wr && sts.grp_last |=> state_q == S_PUSH)
		else $error("finished scan group not pushed");
`endif

endmodule

### hw/rtl/ctkd_dp.sv
module ctkd_dp #(
	parameter int SAMPLE_WIDTH = ctkd_pkg::SAMPLE_WIDTH_DEF,
	parameter int LOCKOUT_SCANS = ctkd_pkg::LOCKOUT_SCANS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	input  logic [ctkd_pkg::FIELD_W-1:0]  sample,
	input  ctkd_pkg::cmd_t                cmd,
	output ctkd_pkg::sts_t                sts,
	output logic                          kind,
	output logic                          pressed,
	output logic [ctkd_pkg::FIELD_W-1:0]  peak,
	output logic [ctkd_pkg::FIELD_W-1:0]  baseline
);

	localparam int EW = (SAMPLE_WIDTH < ctkd_pkg::FIELD_W) ? SAMPLE_WIDTH : ctkd_pkg::FIELD_W;
	localparam int LW = $clog2(LOCKOUT_SCANS + 1);
	localparam int SUMW = EW + 3;
	localparam int DIV_SH = SUMW + 3;
	localparam int MW = DIV_SH - 2;
	localparam int PW = SUMW + MW;
	localparam longint unsigned DIV_MUL =
		((64'd1 << DIV_SH) + 64'(ctkd_pkg::CAL_KEEP - 1)) / 64'(ctkd_pkg::CAL_KEEP);
	localparam int CW = ctkd_pkg::CNT_W;
	localparam int GW = ctkd_pkg::GRP_W;

	logic                  mode_q;
	logic [EW-1:0]         cal_q [ctkd_pkg::CAL_DEPTH];
	logic [EW-1:0]         cal_nx [ctkd_pkg::CAL_DEPTH];
	logic [ctkd_pkg::CAL_DEPTH-1:0] gt;
	logic [ctkd_pkg::CAL_DEPTH-1:0] sh_gt;
	logic [CW-1:0]         cal_cnt_q;
	logic [EW-1:0]         baseline_q;
	logic [GW-1:0]         grp_cnt_q;
	logic [GW-1:0]         pass_cnt_q;
	logic [EW-1:0]         grp_peak_q;
	logic [LW-1:0]         lock_q;
	logic [SUMW-1:0]       acc_q;
	logic [PW-1:0]         prod_q;
	logic [MW-1:0]         div_mul;

	logic                  res_kind_q;
	logic                  res_pressed_q;
	logic [EW-1:0]         res_peak_q;
	logic [EW-1:0]         res_base_q;
	logic                  out_kind_q;
	logic                  out_pressed_q;
	logic [EW-1:0]         out_peak_q;
	logic [EW-1:0]         out_base_q;

	logic [EW-1:0]         s;
	logic [EW-1:0]         mean;
	logic [EW+2:0]         b5;
	logic                  pass_hit;
	logic [GW-1:0]         pass_nx;
	logic [EW-1:0]         peak_nx;
	logic [GW-1:0]         cnt_nx;
	logic [GW-1:0]         grp_size;
	logic [GW-1:0]         need;
	logic [EW-1:0]         q;
	logic [EW+1:0]         q3;
	logic [EW+1:0]         b4;
	logic [EW+3:0]         b10;
	logic                  qual;
	logic [LW-1:0]         lock_base;
	logic [LW-1:0]         lock_set;
	logic [LW-1:0]         lock_nx;
	logic                  scan_pressed;

	assign cfg_ready = 1'b1;
	assign s = sample[EW-1:0];
	assign div_mul = MW'(DIV_MUL);
	assign mean = prod_q[DIV_SH +: EW];

	// keep the calibration set sorted: insert each sample at its place
	always_comb begin
		for (int i = 0; i < ctkd_pkg::CAL_DEPTH; i++) begin
			gt[i] = (CW'(i) < cal_cnt_q) && (cal_q[i] > s);
		end
		sh_gt = {gt[ctkd_pkg::CAL_DEPTH-2:0], 1'b0};
		for (int i = 0; i < ctkd_pkg::CAL_DEPTH; i++) begin
			if ((CW'(i) < cal_cnt_q) && !gt[i]) begin
				cal_nx[i] = cal_q[i];
			end else if (sh_gt[i]) begin
				cal_nx[i] = cal_q[(i > 0) ? i - 1 : 0];
			end else begin
				cal_nx[i] = s;
			end
		end
	end

	always_comb begin
		b5 = (EW+3)'({baseline_q, 2'b00}) + (EW+3)'(baseline_q);
		pass_hit = (EW+1)'(s) > b5[EW+2:2];
		pass_nx = (pass_hit && pass_cnt_q != '1) ? pass_cnt_q + 1'b1 : pass_cnt_q;
		peak_nx = (s > grp_peak_q) ? s : grp_peak_q;
		cnt_nx = grp_cnt_q + 1'b1;
		grp_size = mode_q ? GW'(ctkd_pkg::GROUP_CONT) : GW'(ctkd_pkg::GROUP_NORMAL);
		need = mode_q ? GW'(ctkd_pkg::NEED_CONT) : GW'(ctkd_pkg::NEED_NORMAL);
		q = (pass_nx >= need) ? peak_nx : '0;
		q3 = (EW+2)'({q, 1'b0}) + (EW+2)'(q);
		b4 = (EW+2)'({baseline_q, 2'b00});
		b10 = (EW+4)'({baseline_q, 3'b000}) + (EW+4)'({baseline_q, 1'b0});
		qual = (q3 > b4) && ((EW+4)'(q) < b10);
		lock_base = mode_q ? '0 : lock_q;
		lock_set = qual ? LW'(LOCKOUT_SCANS) : lock_base;
		lock_nx = (lock_set != '0) ? lock_set - 1'b1 : '0;
		scan_pressed = qual && (lock_base == '0);
	end

	assign sts.cal_last = (cal_cnt_q == CW'(ctkd_pkg::CAL_DEPTH - 1));
	assign sts.grp_last = (cnt_nx >= grp_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			cal_cnt_q <= '0;
			baseline_q <= '0;
			grp_cnt_q <= '0;
			pass_cnt_q <= '0;
			grp_peak_q <= '0;
			lock_q <= '0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (cmd.cal_wr) begin
				cal_cnt_q <= sts.cal_last ? '0 : cal_cnt_q + 1'b1;
				grp_cnt_q <= '0;
				pass_cnt_q <= '0;
				grp_peak_q <= '0;
			end else if (cmd.scan_wr) begin
				cal_cnt_q <= '0;
				if (sts.grp_last) begin
					grp_cnt_q <= '0;
					pass_cnt_q <= '0;
					grp_peak_q <= '0;
					lock_q <= lock_nx;
				end else begin
					grp_cnt_q <= cnt_nx;
					pass_cnt_q <= pass_nx;
					grp_peak_q <= peak_nx;
				end
			end
			if (cmd.base_load) begin
				baseline_q <= mean;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cal_wr) begin
			for (int i = 0; i < ctkd_pkg::CAL_DEPTH; i++) begin
				cal_q[i] <= cal_nx[i];
			end
		end
		if (cmd.sum_clear) begin
			acc_q <= '0;
		end else if (cmd.sum_add) begin
			acc_q <= acc_q + SUMW'(cal_q[cmd.sum_idx]);
		end
		if (cmd.mul_load) begin
			prod_q <= PW'(acc_q) * PW'(div_mul);
		end
		if (cmd.scan_wr && sts.grp_last) begin
			res_kind_q <= ctkd_pkg::KIND_SCAN;
			res_pressed_q <= scan_pressed;
			res_peak_q <= q;
			res_base_q <= baseline_q;
		end else if (cmd.base_load) begin
			res_kind_q <= ctkd_pkg::KIND_CAL;
			res_pressed_q <= 1'b0;
			res_peak_q <= '0;
			res_base_q <= mean;
		end
		if (cmd.out_load) begin
			out_kind_q <= res_kind_q;
			out_pressed_q <= res_pressed_q;
			out_peak_q <= res_peak_q;
			out_base_q <= res_base_q;
		end
	end

	assign kind = out_kind_q;
	assign pressed = out_pressed_q;
	assign peak = ctkd_pkg::FIELD_W'(out_peak_q);
	assign baseline = ctkd_pkg::FIELD_W'(out_base_q);

endmodule

### hw/rtl/capacitive_touch_key_detector.sv
// Touch key detector: send pad charge-time samples as input transactions, with operation
// selecting calibration or measurement. Every tenth consecutive calibration sample yields a
// calibration transaction carrying the new baseline, the mean of the middle six of the ten
// sorted samples; every completed scan group (three samples, six when cfg_data is
// written as 1) yields a scan transaction with the qualified peak and the press flag. The
// tenth calibration sample starts the accumulator that walks the six middle entries of the
// sorted set one per cycle, then the divide-by-six multiply and the baseline load. A result
// waits on out_ready while an earlier one is still held, and no new sample is taken until
// it is in the output register. The configuration channel is always ready.
module capacitive_touch_key_detector #(
	parameter int SAMPLE_WIDTH = ctkd_pkg::SAMPLE_WIDTH_DEF,
	parameter int LOCKOUT_SCANS = ctkd_pkg::LOCKOUT_SCANS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [ctkd_pkg::FIELD_W-1:0]  sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic                          pressed,
	output logic [ctkd_pkg::FIELD_W-1:0]  peak,
	output logic [ctkd_pkg::FIELD_W-1:0]  baseline,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);

	ctkd_pkg::cmd_t cmd;
	ctkd_pkg::sts_t sts;

	ctkd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ctkd_dp #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.LOCKOUT_SCANS (LOCKOUT_SCANS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.pressed   (pressed),
		.peak      (peak),
		.baseline  (baseline)
	);

endmodule
